### sv/code_prefix_or_text_substring_match_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the code prefix or text substring match core
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CODE_PREFIX_OR_TEXT_SUBSTRING_MATCH_CORE_MACROS_SVH
`define CODE_PREFIX_OR_TEXT_SUBSTRING_MATCH_CORE_MACROS_SVH

// The property holds in the same cycle as its trigger.
`define CPSM_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// The property holds in the cycle after its trigger.
`define CPSM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### sv/cpsm_pkg.sv
// ----------------------------------------------------------------------------
// cpsm_pkg
// Types, constants and character helpers for the query match core.
// ----------------------------------------------------------------------------
package cpsm_pkg;

  localparam int unsigned MAX_QUERY_DEF = 32;
  localparam int unsigned QUERY_REGS    = 4;
  localparam int unsigned QUERY_CHARS   = QUERY_REGS * 8;
  localparam int unsigned CODE_CHARS    = 5;
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CODE_W        = CODE_CHARS * 8;
  localparam int unsigned IN_DATA_W     = 56;
  localparam int unsigned OUT_DATA_W    = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_LENGTH  = 3'd0,
    REG_QUERY_BYTES_0 = 3'd1,
    REG_QUERY_BYTES_1 = 3'd2,
    REG_QUERY_BYTES_2 = 3'd3,
    REG_QUERY_BYTES_3 = 3'd4
  } cfg_reg_e;

  // Per-item control from the input stage to the search state.
  typedef struct packed {
    logic step;   // a description byte is taken in
    logic clear;  // the entry ends, state returns to zero
  } search_ctl_t;

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'h20;
    return r;
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) r = c - 8'h20;
    return r;
  endfunction

endpackage

### sv/code_prefix_or_text_substring_match_core.sv
// ----------------------------------------------------------------------------
// code_prefix_or_text_substring_match_core
// Query filter for database entries: code prefix or case-free text search.
// ----------------------------------------------------------------------------
// The core takes one item per clock cycle, back to back, and gives the
// result of an entry after its last item has passed the input register
// and then the result register. Each item updates the partial-match
// vector, where every query position is compared with the incoming
// byte in parallel. The input side keeps accepting while a finished
// result waits to be taken; only an entry end that meets a full, stalled
// result register holds the input.
// Write the query registers only while no entry is in flight.
module code_prefix_or_text_substring_match_core #(
  parameter int unsigned MAX_QUERY = cpsm_pkg::MAX_QUERY_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [cpsm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [cpsm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [39:0] entry_code, [47:40] text_byte, [48] byte_present, [55:49] zero
  input  logic [cpsm_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  input  logic                                 s_axis_tlast_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [0] is_match, [7:1] zero
  output logic [cpsm_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o
);

  `include "code_prefix_or_text_substring_match_core_macros.svh"

  localparam int unsigned QLW = $clog2(MAX_QUERY + 1);

  logic [cpsm_pkg::QUERY_CHARS*8-1:0] query;
  logic [QLW-1:0]                     qlen;

  logic                         in_valid_q, in_present_q, in_last_q;
  logic [cpsm_pkg::CODE_W-1:0]  in_code_q;
  logic [7:0]                   in_byte_q;
  logic                         out_valid_q, out_match_q;
  logic                         advance, s_accept, found, match;
  cpsm_pkg::search_ctl_t        ctl;

  assign cfg_ready_o = 1'b1;

  cpsm_cfg #(.MAX_QUERY(MAX_QUERY), .QLW(QLW)) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .query_o (query),
    .qlen_o  (qlen)
  );

  // An item leaves the input register unless it ends an entry and the
  // result register is full and stalled.
  assign advance  = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;

  assign ctl.step  = advance && in_present_q;
  assign ctl.clear = advance && in_last_q;

  cpsm_search #(.MAX_QUERY(MAX_QUERY), .QLW(QLW)) u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .byte_i  (in_byte_q),
    .query_i (query),
    .qlen_i  (qlen),
    .found_o (found)
  );

  cpsm_prefix #(.QLW(QLW)) u_prefix (
    .query_i (query),
    .qlen_i  (qlen),
    .code_i  (in_code_q),
    .found_i (found),
    .match_o (match)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_code_q    <= s_axis_tdata_i[cpsm_pkg::CODE_W-1:0];
      in_byte_q    <= s_axis_tdata_i[cpsm_pkg::CODE_W +: 8];
      in_present_q <= s_axis_tdata_i[cpsm_pkg::CODE_W + 8];
      in_last_q    <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.clear) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.clear) out_match_q <= match;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(cpsm_pkg::OUT_DATA_W-1){1'b0}}, out_match_q};

  `CPSM_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, ctl.clear,
    out_valid_q && out_match_q == $past(match), "entry end did not load its result")
  `CPSM_ASSERT_SAME(a_no_overwrite, clk_i, rst_ni,
    in_valid_q && in_last_q && out_valid_q && !m_axis_tready_i, !advance,
    "pending result would be overwritten")
  `CPSM_ASSERT_NEXT(a_empty_query, clk_i, rst_ni, ctl.clear && qlen == '0,
    out_match_q, "empty query must match every entry")

endmodule

### sv/cpsm_cfg.sv
// ----------------------------------------------------------------------------
// cpsm_cfg
// Query registers and the clamped query length.
// ----------------------------------------------------------------------------
module cpsm_cfg #(
  parameter int unsigned MAX_QUERY = cpsm_pkg::MAX_QUERY_DEF,
  parameter int unsigned QLW       = $clog2(MAX_QUERY + 1)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   wr_i,
  input  logic [cpsm_pkg::CFG_IDX_W-1:0]         index_i,
  input  logic [cpsm_pkg::CFG_DATA_W-1:0]        data_i,
  output logic [cpsm_pkg::QUERY_CHARS*8-1:0]     query_o,
  output logic [QLW-1:0]                         qlen_o
);

  logic [cpsm_pkg::LEN_W-1:0]                                   len_q;
  logic [cpsm_pkg::QUERY_REGS-1:0][cpsm_pkg::CFG_DATA_W-1:0] bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      bytes_q <= '0;
    end else if (wr_i) begin
      unique case (cpsm_pkg::cfg_reg_e'(index_i))
        cpsm_pkg::REG_QUERY_LENGTH:  len_q      <= data_i[cpsm_pkg::LEN_W-1:0];
        cpsm_pkg::REG_QUERY_BYTES_0: bytes_q[0] <= data_i;
        cpsm_pkg::REG_QUERY_BYTES_1: bytes_q[1] <= data_i;
        cpsm_pkg::REG_QUERY_BYTES_2: bytes_q[2] <= data_i;
        cpsm_pkg::REG_QUERY_BYTES_3: bytes_q[3] <= data_i;
        default: ;
      endcase
    end
  end

  assign query_o = bytes_q;

  // Lengths beyond the search width are clamped to it.
  always_comb begin
    if (int'(len_q) > int'(MAX_QUERY)) qlen_o = QLW'(MAX_QUERY);
    else                               qlen_o = QLW'(len_q);
  end

endmodule

### sv/cpsm_search.sv
// ----------------------------------------------------------------------------
// cpsm_search
// Shift-and substring search over the description, one byte per cycle while the input stage steps it.
// ----------------------------------------------------------------------------
module cpsm_search #(
  parameter int unsigned MAX_QUERY = cpsm_pkg::MAX_QUERY_DEF,
  parameter int unsigned QLW       = $clog2(MAX_QUERY + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cpsm_pkg::search_ctl_t              ctl_i,
  input  logic [7:0]                         byte_i,
  input  logic [cpsm_pkg::QUERY_CHARS*8-1:0] query_i,
  input  logic [QLW-1:0]                     qlen_i,
  output logic                               found_o
);

  logic [MAX_QUERY-1:0] hits_q, hits_d, eq, top_sel, hits_new;
  logic                 found_q, found_d;
  logic [7:0]           byte_low;

  assign byte_low = cpsm_pkg::fold_lower(byte_i);

  // Each query position is compared on its own; positions past the length
  // never match, so the hit vector never carries bits beyond it.
  for (genvar j = 0; j < MAX_QUERY; j++) begin : g_pos
    logic [7:0] qc;
    if (j < cpsm_pkg::QUERY_CHARS) begin : g_reg
      assign qc = query_i[j*8 +: 8];
    end else begin : g_zero
      assign qc = 8'h00;
    end
    assign eq[j]      = (QLW'(j) < qlen_i) && (cpsm_pkg::fold_lower(qc) == byte_low);
    assign top_sel[j] = (qlen_i == QLW'(j + 1));
  end

  if (MAX_QUERY > 1) begin : g_shift
    assign hits_new = {hits_q[MAX_QUERY-2:0], 1'b1} & eq;
  end else begin : g_single
    assign hits_new = eq;
  end

  always_comb begin
    found_o = found_q;
    if (ctl_i.step && |(hits_new & top_sel)) found_o = 1'b1;
    hits_d  = ctl_i.step ? hits_new : hits_q;
    found_d = found_o;
    if (ctl_i.clear) begin
      hits_d  = '0;
      found_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q  <= '0;
      found_q <= 1'b0;
    end else begin
      hits_q  <= hits_d;
      found_q <= found_d;
    end
  end

endmodule

### sv/cpsm_prefix.sv
// ----------------------------------------------------------------------------
// cpsm_prefix
// Final decision: empty query, upper-cased code prefix, or text hit.
// ----------------------------------------------------------------------------
module cpsm_prefix #(
  parameter int unsigned QLW = 6
) (
  input  logic [cpsm_pkg::QUERY_CHARS*8-1:0] query_i,
  input  logic [QLW-1:0]                     qlen_i,
  input  logic [cpsm_pkg::CODE_W-1:0]        code_i,
  input  logic                               found_i,
  output logic                               match_o
);

  logic [cpsm_pkg::CODE_CHARS-1:0] char_ok;
  logic                            short_query;

  for (genvar j = 0; j < cpsm_pkg::CODE_CHARS; j++) begin : g_chr
    assign char_ok[j] = (QLW'(j) >= qlen_i) ||
                        (cpsm_pkg::fold_upper(query_i[j*8 +: 8]) == code_i[j*8 +: 8]);
  end

  assign short_query = (qlen_i <= QLW'(cpsm_pkg::CODE_CHARS));
  assign match_o     = (qlen_i == '0) || found_i || (short_query && &char_ok);

endmodule

### sim/tb_code_prefix_or_text_substring_match_core.sv
// ----------------------------------------------------------------------------
// Testbench for the code prefix or text substring match core
// Loads queries through the register channel and streams database entries
// through the core. Each result is checked against a predictor that tracks
// the partial-match vector and the found flag of the current entry. Both
// stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_code_prefix_or_text_substring_match_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cpsm_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 100000;
  localparam int unsigned RESULT_LATENCY = 2;
  localparam int unsigned MAX_SHOWN      = 10;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned RANDOM_ITEMS   = 400;
  localparam int unsigned RANDOM_PHASES  = 10;
  localparam int unsigned IDLE_PCT       = 29;

  // The index field has room for codes that name no register.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef logic [7:0] text_q_t[$];

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                  s_axis_tlast_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  code_prefix_or_text_substring_match_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Predictor copy of the registers and of the search state.
  logic [LEN_W-1:0]         query_len_r;
  logic [63:0]              query_word_r [QUERY_REGS];
  logic [MAX_QUERY_DEF-1:0] partial_hits_r;
  logic                     text_found_r;
  logic                     pending_match_q[$];

  // Query as the stimulus generator sees it.
  logic [7:0]  query_text [QUERY_CHARS];
  int unsigned gen_len;

  bit          calm;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned hold_left;
  int unsigned failures;
  int unsigned items_sent;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [7:0] ascii_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic logic [7:0] ascii_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    logic [7:0] low;
    low = c | 8'h20;
    if (low >= 8'h61 && low <= 8'h7A && $urandom_range(0, 1) == 1) return c ^ 8'h20;
    return c;
  endfunction

  function automatic int unsigned live_length();
    return (query_len_r > MAX_QUERY_DEF) ? MAX_QUERY_DEF : int'(query_len_r);
  endfunction

  function automatic logic [7:0] query_char(input int unsigned i);
    return query_word_r[i / 8][(i % 8) * 8 +: 8];
  endfunction

  // Advances the search by one accepted item and queues the verdict on the
  // entry's last item.
  function automatic void track_item(input logic [CODE_W-1:0] code, input logic [7:0] tbyte,
                                     input logic present, input logic last);
    int unsigned              n;
    int unsigned              j;
    logic [MAX_QUERY_DEF-1:0] eq;
    logic                     match;
    logic                     prefix;
    n = live_length();
    eq = '0;
    if (present) begin
      for (j = 0; j < n; j++) begin
        if (ascii_lower(query_char(j)) == ascii_lower(tbyte)) eq[j] = 1'b1;
      end
      partial_hits_r = {partial_hits_r[MAX_QUERY_DEF-2:0], 1'b1} & eq;
      if (n > 0 && partial_hits_r[n-1]) text_found_r = 1'b1;
    end
    if (last) begin
      if (n == 0) begin
        match = 1'b1;
      end else begin
        match = text_found_r;
        if (n <= CODE_CHARS) begin
          prefix = 1'b1;
          for (j = 0; j < n; j++) begin
            if (ascii_upper(query_char(j)) != code[j*8 +: 8]) prefix = 1'b0;
          end
          if (prefix) match = 1'b1;
        end
      end
      pending_match_q.push_back(match);
      partial_hits_r = '0;
      text_found_r   = 1'b0;
    end
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= MAX_SHOWN) $display("mismatch: %s", msg);
  endfunction

  function automatic void check_result(input logic [OUT_DATA_W-1:0] data);
    logic [OUT_DATA_W-1:0] want;
    if (pending_match_q.size() == 0) begin
      note_failure($sformatf("result %02h with no entry waiting", data));
    end else begin
      want = {{(OUT_DATA_W-1){1'b0}}, pending_match_q.pop_front()};
      if (data !== want) note_failure($sformatf("is_match expected %02h got %02h", want, data));
    end
  endfunction

  // Result side: checks every transfer, stalls at random and serves
  // long hold-off requests.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) check_result(m_axis_tdata_o);
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [CODE_W-1:0] rand_code();
    return {8'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [CODE_W-1:0] code_of(input string s);
    logic [CODE_W-1:0] code;
    int unsigned       i;
    code = '0;
    for (i = 0; i < CODE_CHARS; i++) code[i*8 +: 8] = s[i];
    return code;
  endfunction

  function automatic text_q_t text_of(input string s);
    text_q_t     q;
    int unsigned i;
    for (i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  task automatic send_item(input logic [CODE_W-1:0] code, input logic [7:0] tbyte,
                           input logic present, input logic last);
    // Each cycle before the transfer idles with the same chance.
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'b0, present, tbyte, code};
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    track_item(code, tbyte, present, last);
    items_sent++;
  endtask

  // Sends one entry; hole_pct mixes empty items in between the bytes.
  task automatic send_entry(input logic [CODE_W-1:0] code, input text_q_t txt,
                            input int unsigned hole_pct);
    int unsigned i;
    bit          tail;
    if (txt.size() == 0) begin
      send_item(code, 8'($urandom), 1'b0, 1'b1);
      return;
    end
    tail = hole_pct > 0 && $urandom_range(0, 9) == 0;
    for (i = 0; i < txt.size(); i++) begin
      if ($urandom_range(0, 99) < hole_pct) send_item(code, 8'($urandom), 1'b0, 1'b0);
      send_item(code, txt[i], 1'b1, i == txt.size() - 1 && !tail);
    end
    if (tail) send_item(code, 8'($urandom), 1'b0, 1'b1);
  endtask

  // Stops offering items and waits until every result has been taken.
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_match_q.size() != 0) @(posedge clk_i);
    repeat (RESULT_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_QUERY_LENGTH:  query_len_r = value[LEN_W-1:0];
      REG_QUERY_BYTES_0,
      REG_QUERY_BYTES_1,
      REG_QUERY_BYTES_2,
      REG_QUERY_BYTES_3: query_word_r[idx - REG_QUERY_BYTES_0] = value;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes all query words and then the length; the upper bits of the
  // length transfer carry random junk.
  task automatic set_query(input text_q_t chars, input logic [LEN_W-1:0] len);
    int unsigned           i;
    int unsigned           r;
    logic [63:0]           w;
    logic [CFG_DATA_W-1:0] len_word;
    wait_idle();
    for (i = 0; i < QUERY_CHARS; i++) query_text[i] = (i < chars.size()) ? chars[i] : 8'($urandom);
    for (r = 0; r < QUERY_REGS; r++) begin
      for (i = 0; i < 8; i++) w[i*8 +: 8] = query_text[r*8 + i];
      write_reg(CFG_IDX_W'(REG_QUERY_BYTES_0 + r), w);
    end
    len_word = {$urandom, $urandom};
    len_word[LEN_W-1:0] = len;
    write_reg(REG_QUERY_LENGTH, len_word);
    gen_len = (len > MAX_QUERY_DEF) ? MAX_QUERY_DEF : int'(len);
  endtask

  task automatic test_default_query();
    text_q_t none;
    send_entry(rand_code(), none, 0);
    send_entry(rand_code(), text_of("x"), 0);
    // A write to an index with no register behind it must change nothing.
    wait_idle();
    write_reg(REG_UNUSED_HI, '1);
    write_reg(REG_UNUSED_LO, '1);
    send_entry(rand_code(), none, 0);
  endtask

  task automatic test_code_prefix();
    text_q_t none;
    set_query(text_of("aB"), LEN_W'(2));
    send_entry(code_of("ABQRS"), none, 0);
    send_entry(code_of("abqrs"), none, 0);
    send_entry(code_of("ZZZZZ"), text_of("xAb"), 0);
    // An empty item in the middle leaves the partial match alive.
    send_item(code_of("ZZZZZ"), 8'h61, 1'b1, 1'b0);
    send_item(code_of("ZZZZZ"), 8'h62, 1'b0, 1'b0);
    send_item(code_of("ZZZZZ"), 8'h62, 1'b1, 1'b1);
    send_entry(code_of("ZZZZZ"), text_of("a?b"), 0);
    set_query(text_of("abcdef"), LEN_W'(6));
    send_entry(code_of("ABCDE"), none, 0);
    set_query(text_of("abcde"), LEN_W'(5));
    send_entry(code_of("ABCDE"), none, 0);
  endtask

  task automatic test_raw_bytes();
    text_q_t none;
    text_q_t raw;
    text_q_t other;
    // Bytes above 0x7F and zero bytes compare exactly, without folding.
    raw   = '{8'hC1, 8'h00, 8'hE1};
    other = '{8'hE1, 8'h00, 8'hE1};
    set_query(raw, LEN_W'(3));
    send_entry(rand_code(), raw, 0);
    send_entry(rand_code(), other, 0);
    send_entry({16'h5A5A, 8'hE1, 8'h00, 8'hC1}, none, 0);
  endtask

  task automatic test_long_length();
    text_q_t none;
    set_query(none, '1);
    send_entry(code_of("AAAAA"), none, 0);
  endtask

  task automatic random_query(input int unsigned phase);
    text_q_t          chars;
    logic [LEN_W-1:0] len;
    int unsigned      pick;
    int unsigned      i;
    bit               narrow;
    logic [7:0]       c;
    pick = $urandom_range(0, 9);
    if (phase == 0)      len = LEN_W'(MAX_QUERY_DEF);
    else if (phase == 1) len = '1;
    else if (phase == 3) len = '0;
    else if (pick == 0)  len = '0;
    else if (pick <= 3)  len = LEN_W'($urandom_range(1, CODE_CHARS));
    else if (pick <= 6)  len = LEN_W'($urandom_range(CODE_CHARS + 1, 16));
    else if (pick == 7)  len = LEN_W'($urandom_range(17, MAX_QUERY_DEF));
    else                 len = LEN_W'($urandom_range(MAX_QUERY_DEF, 63));
    narrow = $urandom_range(0, 1);
    for (i = 0; i < QUERY_CHARS; i++) begin
      if (narrow)                           c = 8'h61 + 8'($urandom_range(0, 2));
      else if ($urandom_range(0, 9) < 7)    c = 8'h61 + 8'($urandom_range(0, 25));
      else                                  c = 8'($urandom);
      chars.push_back(flip_case(c));
    end
    set_query(chars, len);
  endtask

  // Most entries are built around the query so that the search reaches
  // deep matches; the rest are code prefixes, empty entries and noise.
  task automatic send_random_entry();
    text_q_t           txt;
    logic [CODE_W-1:0] code;
    int unsigned       kind;
    int unsigned       i;
    int unsigned       k;
    logic [7:0]        c;
    code = rand_code();
    kind = $urandom_range(0, 9);
    if (kind <= 4) begin
      repeat ($urandom_range(0, 4)) txt.push_back(8'($urandom));
      for (i = 0; i < gen_len; i++) begin
        c = flip_case(query_text[i]);
        if ($urandom_range(0, 7) == 0) c = 8'($urandom);
        txt.push_back(c);
      end
      repeat ($urandom_range(0, 3)) txt.push_back(8'($urandom));
    end else if (kind == 5) begin
      // A false start on the query right before the full query.
      k = (gen_len > 1) ? $urandom_range(1, gen_len - 1) : 0;
      for (i = 0; i < k; i++) txt.push_back(flip_case(query_text[i]));
      for (i = 0; i < gen_len; i++) txt.push_back(flip_case(query_text[i]));
    end else if (kind == 6) begin
      for (i = 0; i < CODE_CHARS && i < gen_len; i++) code[i*8 +: 8] = ascii_upper(query_text[i]);
      if ($urandom_range(0, 5) == 0) code[$urandom_range(0, CODE_CHARS - 1)*8 +: 8] = 8'($urandom);
      repeat ($urandom_range(0, 3)) txt.push_back(8'($urandom));
    end else if (kind >= 8) begin
      repeat ($urandom_range(1, 10)) begin
        if ($urandom_range(0, 1) == 1) txt.push_back(flip_case(query_text[$urandom_range(0, 3)]));
        else                           txt.push_back(8'($urandom));
      end
    end
    send_entry(code, txt, 10);
  endtask

  task automatic test_random_entries();
    int unsigned phase;
    int unsigned start;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_query(phase);
      calm = (phase == 2 || phase == 5);
      // The result side holds off while items keep coming, so the core
      // fills up and stalls its input.
      if (phase == 5) hold_requests++;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS / RANDOM_PHASES) send_random_entry();
      calm = 1'b0;
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = REG_QUERY_LENGTH;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    calm            = 1'b0;
    hold_requests   = 0;
    hold_served     = 0;
    hold_left       = 0;
    failures        = 0;
    items_sent      = 0;
    cycle_count     = 0;
    gen_len         = 0;
    query_len_r     = '0;
    partial_hits_r  = '0;
    text_found_r    = 1'b0;
    foreach (query_word_r[i]) query_word_r[i] = '0;
    foreach (query_text[i]) query_text[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_query();
    test_code_prefix();
    test_raw_bytes();
    test_long_length();
    test_random_entries();
    wait_idle();
    repeat (RESULT_LATENCY * 4) @(posedge clk_i);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
